### hw/rtl/svt_pkg.sv
// ---------------------------------------------------------------------------
// svt_pkg: shared types and constants for the sorted value table
// Table depth, derived index widths, action and status codes, and the
// command that is broadcast to every cell of the row.
// ---------------------------------------------------------------------------
`default_nettype none

package svt_pkg;

  // Table geometry
  localparam int DEPTH   = 64;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Read-out selection is gathered in groups of cells, registered per group
  localparam int GROUP   = 8;
  localparam int NGROUP  = (DEPTH + GROUP - 1) / GROUP;

  // Stream payload widths (rounded up to whole bytes)
  localparam int IN_W    = 48;
  localparam int OUT_W   = 80;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FAIL = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Command seen by every cell in the update cycle
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/sorted_value_table.sv
// ---------------------------------------------------------------------------
// sorted_value_table: bounded table of signed values kept in ascending order
// One result item per request item: insert, remove first equal, read at a
// 1-based position, or clear.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream, results leave on the m_ stream; each
//   accepted request gives exactly one result, in order.
//   After the accepting edge a request passes the update of the cell row
//   (all entries shift at once), the group stage of the read-out select,
//   and the final reduce into the output register.
//   The block takes one item at a time and is ready again in the cycle
//   after the load.
//   The next request is taken while a finished result still waits on m_;
//   the block only holds in its last step if the previous result is still
//   not taken, so a stalled receiver stops the block after one more item.
//   Reset (rst, synchronous) empties the table and drops any pending
//   result; the stored entries themselves are not cleared.
//   Insert into a full table reports full; remove of an absent value or a
//   read outside 1..count reports fail. Clear always succeeds.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_value_table (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // s_tdata: action[1:0], value[33:2], position[40:34], zero fill
  input  wire logic [svt_pkg::IN_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // m_tdata: status[1:0], read_value[33:2], count[40:34], largest[72:41], zero fill
  output logic [svt_pkg::OUT_W-1:0]       m_tdata
);
  import svt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPDATE = 4'b0010,
    S_GATHER = 4'b0100,
    S_REDUCE = 4'b1000
  } state_t;

  state_t                   state;
  state_t                   state_next;
  action_t                  act;
  logic signed [DATA_W-1:0] val;
  logic [POS_W-1:0]         pos;
  logic [CNT_W-1:0]         used;
  status_t                  status;
  logic                     rd_ok;
  logic                     full;
  logic                     found;
  logic                     pos_ok;
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] rd_data;
  logic signed [DATA_W-1:0] last_data;
  logic                     out_load;

  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_read;
  logic [COUNT_W-1:0]       out_count;
  logic signed [DATA_W-1:0] out_largest;

  assign s_tready = (state == S_IDLE);
  assign full     = (used == CNT_W'(DEPTH));
  assign pos_ok   = (pos != '0) && (CMP_W'(pos) <= CMP_W'(used));
  assign out_load = (state == S_REDUCE) && (!m_tvalid || m_tready);

  // Broadcast command for the cell row
  always_comb begin
    cmd.value = val;
    cmd.ins   = (state == S_UPDATE) && (act == ACT_INSERT) && !full;
    cmd.rem   = (state == S_UPDATE) && (act == ACT_REMOVE) && found;
  end

  svt_array u_array (
    .clk       (clk),
    .cmd       (cmd),
    .used      (used),
    .rd_en     (rd_ok),
    .rd_sel    (CNT_W'(pos - POS_W'(1))),
    .found     (found),
    .rd_data   (rd_data),
    .last_data (last_data)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_UPDATE;
      S_UPDATE: state_next = S_GATHER;
      S_GATHER: state_next = S_REDUCE;
      S_REDUCE: if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act <= action_t'(s_tdata[1:0]);
      val <= s_tdata[33:2];
      pos <= s_tdata[40:34];
    end
  end

  // Count, status and read qualifier, settled in the update cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      rd_ok <= 1'b0;
    end else if (state == S_UPDATE) begin
      rd_ok <= (act == ACT_READ) && pos_ok;
      unique case (act)
        ACT_INSERT: if (!full) used <= used + CNT_W'(1);
        ACT_REMOVE: if (found) used <= used - CNT_W'(1);
        ACT_READ:   used <= used;
        ACT_CLEAR:  used <= '0;
        default:    used <= used;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPDATE) begin
      unique case (act)
        ACT_INSERT: status <= full ? ST_FULL : ST_DONE;
        ACT_REMOVE: status <= found ? ST_DONE : ST_FAIL;
        ACT_READ:   status <= pos_ok ? ST_DONE : ST_FAIL;
        ACT_CLEAR:  status <= ST_DONE;
        default:    status <= ST_DONE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status  <= status;
      out_read    <= rd_data;
      out_count   <= COUNT_W'(used);
      out_largest <= last_data;
    end
  end

  assign m_tdata = {(OUT_W - 73)'(0), out_largest, out_count, out_read, out_status};

endmodule

`default_nettype wire

### hw/rtl/svt_cell.sv
// ---------------------------------------------------------------------------
// svt_cell: one entry of the sorted row
// Holds one value, compares it against the broadcast value, and on an
// update takes the new value, its left neighbor's, or its right neighbor's.
// ---------------------------------------------------------------------------
`default_nettype none

module svt_cell (
  input  wire logic                             clk,
  input  wire svt_pkg::cell_cmd_t               cmd,
  input  wire logic                             valid,
  input  wire logic signed [svt_pkg::DATA_W-1:0] left_data,
  input  wire logic                             left_shift,
  input  wire logic signed [svt_pkg::DATA_W-1:0] right_data,
  output logic signed [svt_pkg::DATA_W-1:0]      data,
  output logic                                  ins_shift,
  output logic                                  match
);
  import svt_pkg::*;

  logic rem_take;

  // Position flags: an insert lands after equal entries, a remove closes
  // the gap from the first equal entry onward
  always_comb begin
    ins_shift = !valid || (data > cmd.value);
    rem_take  = valid && (data >= cmd.value);
    match     = valid && (data == cmd.value);
  end

  // Entry update
  always_ff @(posedge clk) begin
    if (cmd.ins && ins_shift) begin
      data <= left_shift ? left_data : cmd.value;
    end else if (cmd.rem && rem_take) begin
      data <= right_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/svt_array.sv
// ---------------------------------------------------------------------------
// svt_array: row of cells with match detect and registered read-out
// Wires each cell to its neighbors, reduces the match flags, and selects
// the read entry and the last entry through a registered group stage.
// ---------------------------------------------------------------------------
`default_nettype none

module svt_array (
  input  wire logic                              clk,
  input  wire svt_pkg::cell_cmd_t                cmd,
  input  wire logic [svt_pkg::CNT_W-1:0]         used,
  input  wire logic                              rd_en,
  input  wire logic [svt_pkg::CNT_W-1:0]         rd_sel,
  output logic                                   found,
  output logic signed [svt_pkg::DATA_W-1:0]      rd_data,
  output logic signed [svt_pkg::DATA_W-1:0]      last_data
);
  import svt_pkg::*;

  logic signed [DATA_W-1:0] cell_data     [DEPTH];
  logic                     cell_shift    [DEPTH];
  logic                     cell_match    [DEPTH];
  logic [DATA_W-1:0]        grp_rd        [NGROUP];
  logic [DATA_W-1:0]        grp_last      [NGROUP];
  logic [DATA_W-1:0]        grp_rd_next   [NGROUP];
  logic [DATA_W-1:0]        grp_last_next [NGROUP];
  logic [CNT_W-1:0]         last_sel;

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic                     left_s;
    logic signed [DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = cell_data[0];
      assign left_s = 1'b0;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
      assign left_s = cell_shift[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    svt_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .valid      (CNT_W'(i) < used),
      .left_data  (left_d),
      .left_shift (left_s),
      .right_data (right_d),
      .data       (cell_data[i]),
      .ins_shift  (cell_shift[i]),
      .match      (cell_match[i])
    );
  end

  // Any held entry equal to the broadcast value
  always_comb begin
    found = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      found = found | cell_match[i];
    end
  end

  // Last held entry; wraps past the row when empty so nothing is selected
  assign last_sel = used - CNT_W'(1);

  // Group select: masked pick within each group of cells
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_rd_next[g]   = '0;
      grp_last_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < DEPTH) begin
          if (rd_en && (rd_sel == CNT_W'(g * GROUP + k))) begin
            grp_rd_next[g] = cell_data[g * GROUP + k];
          end
          if (last_sel == CNT_W'(g * GROUP + k)) begin
            grp_last_next[g] = cell_data[g * GROUP + k];
          end
        end
      end
    end
  end

  // Group stage registers
  always_ff @(posedge clk) begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_rd[g]   <= grp_rd_next[g];
      grp_last[g] <= grp_last_next[g];
    end
  end

  // Final OR across groups
  always_comb begin
    rd_data   = '0;
    last_data = '0;
    for (int g = 0; g < NGROUP; g++) begin
      rd_data   = rd_data | grp_rd[g];
      last_data = last_data | grp_last[g];
    end
  end

endmodule

`default_nettype wire

### sim/sorted_value_table_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_value_table_tb: self-checking bench for the sorted value table
// Drives insert, remove, read and clear requests on the s_ stream. A local
// model of the sorted table predicts every result that no directed row gives.
// Each result on m_ is compared field by field with the oldest expectation.
// A short directed table covers empty, extreme and duplicate cases. Random
// phases follow, with bursty sender traffic and changing receiver stalls.
// ---------------------------------------------------------------------------
module sorted_value_table_tb;
  import svt_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int RANDOM_ITEMS = 1550;
  localparam int DRAIN_CYCLES = 24;

  localparam logic signed [DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] largest;
  } table_result_t;

  typedef struct {
    action_t                  act;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
    bit                       typed;
    table_result_t            res;
  } dir_row_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  // model of the table contents
  logic signed [DATA_W-1:0] held [DEPTH];
  int                       held_count = 0;

  table_result_t pending_q [$];
  dir_row_t      dir_rows [$];
  table_result_t no_result;

  int failures   = 0;
  int n_sent     = 0;
  int cycles     = 0;
  int burst_left = 0;
  bit tx_up      = 1'b0;

  // receiver stall pattern
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;

  sorted_value_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one request to the table model and return its result
  function automatic table_result_t table_apply(input action_t act,
                                                input logic signed [DATA_W-1:0] val,
                                                input logic [POS_W-1:0] pos);
    table_result_t res;
    int at;
    int k;
    res.status     = ST_DONE;
    res.read_value = '0;
    case (act)
      ACT_INSERT: begin
        if (held_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // new value lands after its equals
          at = 0;
          while (at < held_count && held[at] <= val) at++;
          for (k = held_count; k > at; k--) held[k] = held[k-1];
          held[at] = val;
          held_count++;
        end
      end
      ACT_REMOVE: begin
        at = 0;
        while (at < held_count && held[at] != val) at++;
        if (at >= held_count) begin
          res.status = ST_FAIL;
        end else begin
          for (k = at; k + 1 < held_count; k++) held[k] = held[k+1];
          held_count--;
        end
      end
      ACT_READ: begin
        if (int'(pos) >= 1 && int'(pos) <= held_count) begin
          res.read_value = held[int'(pos) - 1];
        end else begin
          res.status = ST_FAIL;
        end
      end
      default: begin
        held_count = 0;
      end
    endcase
    res.count   = COUNT_W'(held_count);
    res.largest = (held_count > 0) ? held[held_count-1] : '0;
    return res;
  endfunction

  function automatic void add_row(input action_t act, input logic signed [DATA_W-1:0] val,
                                  input int pos, input bit typed,
                                  input status_t st = ST_DONE,
                                  input logic signed [DATA_W-1:0] rd = '0,
                                  input int cnt = 0,
                                  input logic signed [DATA_W-1:0] big = '0);
    dir_row_t r;
    r.act            = act;
    r.value          = val;
    r.pos            = POS_W'(pos);
    r.typed          = typed;
    r.res.status     = st;
    r.res.read_value = rd;
    r.res.count      = COUNT_W'(cnt);
    r.res.largest    = big;
    dir_rows.push_back(r);
  endfunction

  // Queue the expectation, present one item and hold it until taken
  task automatic send_item(input action_t act, input logic signed [DATA_W-1:0] val,
                           input logic [POS_W-1:0] pos, input bit typed,
                           input table_result_t typed_res);
    table_result_t predicted;
    predicted = table_apply(act, val, pos);
    if (typed) pending_q.push_back(typed_res);
    else pending_q.push_back(predicted);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, pos, val, act};
    tx_up = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
    // burst bookkeeping: drop valid for a random gap at the end of a burst
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      tx_up = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Stop sending until every outstanding result has come back
  task automatic wait_empty();
    if (tx_up) begin
      s_tvalid <= 1'b0;
      tx_up = 1'b0;
    end
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value(input bit narrow);
    if (narrow) return DATA_W'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 9))
      0:       return VMIN;
      1:       return VMAX;
      2:       return ($urandom_range(0, 1) != 0) ? '0 : -1;
      default: return $urandom;
    endcase
  endfunction

  // Random mix; weights in percent, clear takes what is left
  task automatic run_phase(input int n, input int ins_w, input int rem_w,
                           input int rd_w, input bit narrow);
    int r;
    int j;
    action_t act;
    logic signed [DATA_W-1:0] val;
    logic [POS_W-1:0] pos;
    for (j = 0; j < n; j++) begin
      r   = $urandom_range(0, 99);
      val = pick_value(narrow);
      pos = POS_W'($urandom);
      if (r < ins_w) begin
        act = ACT_INSERT;
      end else if (r < ins_w + rem_w) begin
        act = ACT_REMOVE;
        // mostly remove something that is held
        if (held_count > 0 && $urandom_range(0, 3) != 0)
          val = held[$urandom_range(0, held_count - 1)];
      end else if (r < ins_w + rem_w + rd_w) begin
        act = ACT_READ;
        if ($urandom_range(0, 4) != 0) pos = POS_W'($urandom_range(0, held_count + 1));
      end else begin
        act = ACT_CLEAR;
      end
      send_item(act, val, pos, 1'b0, no_result);
    end
  endtask

  // Insert into a cleared table until it is full and then some more
  task automatic fill_table(input bit narrow);
    send_item(ACT_CLEAR, pick_value(narrow), POS_W'($urandom), 1'b0, no_result);
    run_phase(DEPTH + $urandom_range(2, 8), 100, 0, 0, narrow);
  endtask

  task automatic check_result(input logic [OUT_W-1:0] d);
    table_result_t want;
    if (pending_q.size() == 0) begin
      $error("unexpected result item: %h", d);
      failures++;
      return;
    end
    want = pending_q.pop_front();
    if (d[1:0] !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, d[1:0]);
      failures++;
    end
    if (d[33:2] !== want.read_value) begin
      $error("read_value: expected %0d, got %0d", want.read_value, $signed(d[33:2]));
      failures++;
    end
    if (d[40:34] !== want.count) begin
      $error("count: expected %0d, got %0d", want.count, d[40:34]);
      failures++;
    end
    if (d[72:41] !== want.largest) begin
      $error("largest: expected %0d, got %0d", want.largest, $signed(d[72:41]));
      failures++;
    end
  endtask

  // Result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 9) < 7);
      2:       m_tready <= ($urandom_range(0, 9) < 3);
      default: m_tready <= (rx_tick % 4 == 0);
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int ins_w;
    int rem_w;
    int rd_w;
    int n_phase;

    no_result.status     = ST_DONE;
    no_result.read_value = '0;
    no_result.count      = '0;
    no_result.largest    = '0;

    // directed table: empty table, extremes, duplicates, bad positions
    add_row(ACT_READ,   '0,   1, 1'b1, ST_FAIL, 0, 0, 0);
    add_row(ACT_REMOVE, 5,    0, 1'b1, ST_FAIL, 0, 0, 0);
    add_row(ACT_CLEAR,  '0,   0, 1'b1, ST_DONE, 0, 0, 0);
    add_row(ACT_INSERT, VMAX, 0, 1'b1, ST_DONE, 0, 1, VMAX);
    add_row(ACT_INSERT, VMIN, 0, 1'b1, ST_DONE, 0, 2, VMAX);
    add_row(ACT_READ,   '0,   1, 1'b1, ST_DONE, VMIN, 2, VMAX);
    add_row(ACT_READ,   '0,   2, 1'b1, ST_DONE, VMAX, 2, VMAX);
    add_row(ACT_READ,   '0,   0, 1'b1, ST_FAIL, 0, 2, VMAX);
    add_row(ACT_READ,   '0,   3, 1'b1, ST_FAIL, 0, 2, VMAX);
    add_row(ACT_READ,   '0, 127, 1'b1, ST_FAIL, 0, 2, VMAX);
    add_row(ACT_INSERT, 0,    0, 1'b0);
    add_row(ACT_INSERT, 0,   99, 1'b0);
    add_row(ACT_INSERT, -1,   0, 1'b0);
    add_row(ACT_INSERT, 1,    0, 1'b0);
    add_row(ACT_READ,   '0,   3, 1'b0);
    add_row(ACT_REMOVE, 0,    0, 1'b0);
    add_row(ACT_REMOVE, 42,   0, 1'b0);
    add_row(ACT_REMOVE, VMAX, 0, 1'b0);
    add_row(ACT_READ,   '0,   4, 1'b0);
    add_row(ACT_REMOVE, VMIN, 0, 1'b0);
    add_row(ACT_INSERT, 32'sh5555_5555, 7'h2A, 1'b0);
    add_row(ACT_READ,   '0,  64, 1'b0);
    add_row(ACT_CLEAR,  32'shAAAA_AAAA, 7'h55, 1'b1, ST_DONE, 0, 0, 0);
    add_row(ACT_READ,   '0,   1, 1'b1, ST_FAIL, 0, 0, 0);
    add_row(ACT_INSERT, 32'shAAAA_AAAA, 0, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].act, dir_rows[i].value, dir_rows[i].pos,
                dir_rows[i].typed, dir_rows[i].res);

    // narrow values first so duplicates and remove hits are common
    run_phase(150, 45, 25, 28, 1'b1);
    // full table: refused inserts, reads near the top, churn
    fill_table(1'b0);
    run_phase(80, 35, 15, 50, 1'b0);
    wait_empty();
    // drain down to empty and past it
    run_phase(DEPTH + 20, 0, 80, 20, 1'b0);

    n_phase = 0;
    while (n_sent < dir_rows.size() + RANDOM_ITEMS) begin
      n_phase++;
      if (n_phase % 4 == 0) begin
        fill_table($urandom_range(0, 1) != 0);
      end else begin
        ins_w = $urandom_range(25, 75);
        rem_w = $urandom_range(5, 95 - ins_w);
        rd_w  = 98 - ins_w - rem_w - $urandom_range(0, 2);
        run_phase($urandom_range(60, 200), ins_w, rem_w, rd_w, $urandom_range(0, 2) == 0);
      end
      if (n_phase % 5 == 0) wait_empty();
    end

    wait_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/svt_pkg.sv
hw/rtl/svt_cell.sv
hw/rtl/svt_array.sv
hw/rtl/sorted_value_table.sv
sim/sorted_value_table_tb.sv
